// File: rtl/keypad_debounce_repeat_fifo_top_macros.svh
// Assertion macros shared by the keypad controller RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KEYPAD_DEBOUNCE_REPEAT_FIFO_TOP_MACROS_SVH
`define KEYPAD_DEBOUNCE_REPEAT_FIFO_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KDR_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("keypad controller check failed");

// Next-cycle implication, disabled during reset.
`define KDR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("keypad controller check failed");

`endif

// File: rtl/kdr_pkg.sv
// Types and constants of the keypad controller.
// No dependencies; used by the core, the output buffer and the top level.
package kdr_pkg;

  localparam logic [6:0] CAPTURE_COUNT = 7'd3;
  localparam logic [6:0] REPEAT_COUNT  = 7'd75;
  localparam logic [6:0] RELOAD_COUNT  = 7'd60;

  localparam logic [7:0] CMD_POP    = 8'd0;
  localparam logic [7:0] CMD_STATUS = 8'd1;
  localparam logic [7:0] CMD_COUNT  = 8'd2;
  localparam logic [7:0] CMD_LED0   = 8'd10;
  localparam logic [7:0] CMD_LED1   = 8'd11;
  localparam logic [7:0] CMD_LED2   = 8'd12;
  localparam logic [7:0] CMD_LED3   = 8'd13;
  localparam logic [7:0] CMD_SOUND  = 8'd20;
  localparam logic [7:0] CMD_REPEAT = 8'd21;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       click;
    logic       alarm;
    logic [3:0] led_bits;
  } rsp_t;

endpackage

// File: rtl/kdr_req_if.sv
// Request channel of the keypad controller: scan ticks and bus commands.
// No dependencies.
interface kdr_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_code;
  logic [7:0] command;
  logic [7:0] argument;

  modport source(output valid, func, key_code, command, argument, input ready);
  modport sink(input valid, func, key_code, command, argument, output ready);
endinterface

// File: rtl/kdr_rsp_if.sv
// Response channel of the keypad controller: one word per request.
// No dependencies.
interface kdr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic       click;
  logic       alarm;
  logic [3:0] led_bits;

  modport source(output valid, read_data, read_valid, click, alarm, led_bits, input ready);
  modport sink(input valid, read_data, read_valid, click, alarm, led_bits, output ready);
endinterface

// File: rtl/keypad_debounce_repeat_fifo_top.sv
// Keypad controller top level: core with result stage and output buffer.
// Depends on kdr_pkg, kdr_req_if, kdr_rsp_if, kdr_core and kdr_skid.
//
// req carries one word per scan tick (func = 0, key_code) or bus command
// (func = 1, command, argument). Every accepted word returns exactly one
// word on rsp: read_data/read_valid for pop, status and count commands,
// click and alarm for captured or dropped keys, and the LED state.
// A key held unchanged enters a ring of FIFO_DEPTH entries on its fourth tick;
// with repeat on it enters again on the 76th tick and then every 16 ticks.
// Each word is registered in the result stage and then in the output buffer
// before it leaves on rsp. One word is taken every cycle unless rsp stalls and
// all three results are held, as each word updates a few registers and one ring
// entry and the ring memory is read once per word into a register.
// Reset clears the pointers, the debounce state and the LEDs, sets sound on
// and repeat off; the ring contents are not cleared and no startup pass runs.
// When rsp stalls, the result stage and a two-word buffer hold up to three
// results; req.ready drops once all three are occupied and rises again right
// after the edge at which rsp takes a word.
module keypad_debounce_repeat_fifo_top #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  kdr_req_if.sink   req,
  kdr_rsp_if.source rsp
);

  logic          res_valid;
  logic          res_ready;
  kdr_pkg::rsp_t res_data;

  kdr_core #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  kdr_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .in_valid(res_valid),
    .in_ready(res_ready),
    .in_data (res_data),
    .rsp     (rsp)
  );

endmodule

// File: rtl/kdr_core.sv
// Debounce, repeat, key FIFO and command decode with a one-word result stage.
// Depends on kdr_pkg, kdr_req_if and the assertion macro header.
`include "keypad_debounce_repeat_fifo_top_macros.svh"

module kdr_core #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  kdr_req_if.sink       req,
  output logic          res_valid,
  input  logic          res_ready,
  output kdr_pkg::rsp_t res_data
);

  localparam int IW = $clog2(FIFO_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);
  localparam logic [IW-1:0] FULL_OCC = IW'(FIFO_DEPTH - 2);
  localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(FIFO_DEPTH);

  logic [7:0]    key_store [FIFO_DEPTH];
  logic [7:0]    mem_q;

  logic [IW-1:0] w_idx, w_idx_next;
  logic [IW-1:0] r_idx, r_idx_next;
  logic [6:0]    hold_count, hold_count_next;
  logic [7:0]    held_key, held_key_next;
  logic [7:0]    latest_scan, latest_scan_next;
  logic [3:0]    led_reg, led_reg_next;
  logic          sound_enable, sound_enable_next;
  logic          repeat_enable, repeat_enable_next;

  logic          s1_valid;
  logic          s1_pop;
  kdr_pkg::rsp_t s1_data;

  logic          accept;
  logic          arg_on;
  logic          key_hit;
  logic          capture;
  logic          drop;
  logic          wr_en;
  logic          pop_hit;
  logic          pop_empty;
  logic [IW-1:0] occ;
  kdr_pkg::rsp_t res_next;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    idx_inc = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  assign req.ready = !s1_valid || res_ready;
  assign accept    = req.valid && req.ready;
  assign arg_on    = (req.argument != 8'd0);
  assign key_hit   = (held_key == req.key_code);
  assign pop_empty = accept && req.func && (req.command == kdr_pkg::CMD_POP) && (r_idx == w_idx);

  assign occ = (w_idx >= r_idx) ? (w_idx - r_idx)
                                : IW'({1'b0, w_idx} + DEPTH_W - {1'b0, r_idx});

  always_comb begin
    w_idx_next         = w_idx;
    r_idx_next         = r_idx;
    hold_count_next    = hold_count;
    held_key_next      = held_key;
    latest_scan_next   = latest_scan;
    led_reg_next       = led_reg;
    sound_enable_next  = sound_enable;
    repeat_enable_next = repeat_enable;
    capture            = 1'b0;
    drop               = 1'b0;
    wr_en              = 1'b0;
    pop_hit            = 1'b0;
    res_next           = '0;

    if (accept) begin
      if (!req.func) begin
        latest_scan_next = req.key_code;
        if (req.key_code == 8'd0) begin
          hold_count_next = 7'd0;
        end else if (hold_count == 7'd0) begin
          held_key_next   = req.key_code;
          hold_count_next = 7'd1;
        end else if (hold_count == kdr_pkg::CAPTURE_COUNT) begin
          if (key_hit) begin
            capture         = 1'b1;
            hold_count_next = kdr_pkg::CAPTURE_COUNT + 7'd1;
          end else begin
            hold_count_next = 7'd0;
          end
        end else if (hold_count == kdr_pkg::REPEAT_COUNT) begin
          // repeat off: park at the repeat count
          if (repeat_enable) begin
            if (key_hit) begin
              capture         = 1'b1;
              hold_count_next = kdr_pkg::RELOAD_COUNT;
            end else begin
              hold_count_next = 7'd0;
            end
          end
        end else begin
          hold_count_next = key_hit ? hold_count + 7'd1 : 7'd0;
        end

        // one more key would fill the ring to DEPTH-1: drop it
        if (capture) begin
          drop = (occ == FULL_OCC);
          if (!drop) begin
            wr_en      = 1'b1;
            w_idx_next = idx_inc(w_idx);
          end
        end
      end else begin
        case (req.command)
          kdr_pkg::CMD_POP: begin
            res_next.read_valid = 1'b1;
            if (r_idx != w_idx) begin
              pop_hit    = 1'b1;
              r_idx_next = idx_inc(r_idx);
            end
          end
          kdr_pkg::CMD_STATUS: begin
            res_next.read_valid = 1'b1;
            res_next.read_data  = latest_scan;
            r_idx_next          = w_idx;
          end
          kdr_pkg::CMD_COUNT: begin
            res_next.read_valid = 1'b1;
            res_next.read_data  = 8'(occ);
          end
          kdr_pkg::CMD_LED0:   led_reg_next[0]    = arg_on;
          kdr_pkg::CMD_LED1:   led_reg_next[1]    = arg_on;
          kdr_pkg::CMD_LED2:   led_reg_next[2]    = arg_on;
          kdr_pkg::CMD_LED3:   led_reg_next[3]    = arg_on;
          kdr_pkg::CMD_SOUND:  sound_enable_next  = arg_on;
          kdr_pkg::CMD_REPEAT: repeat_enable_next = arg_on;
          default: ;
        endcase
      end
    end

    res_next.click    = capture && sound_enable;
    res_next.alarm    = drop && sound_enable;
    res_next.led_bits = led_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_idx         <= '0;
      r_idx         <= '0;
      hold_count    <= 7'd0;
      held_key      <= 8'd0;
      latest_scan   <= 8'd0;
      led_reg       <= 4'd0;
      sound_enable  <= 1'b1;
      repeat_enable <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      w_idx         <= w_idx_next;
      r_idx         <= r_idx_next;
      hold_count    <= hold_count_next;
      held_key      <= held_key_next;
      latest_scan   <= latest_scan_next;
      led_reg       <= led_reg_next;
      sound_enable  <= sound_enable_next;
      repeat_enable <= repeat_enable_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (res_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // result word; hold it while the buffer is full
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= res_next;
      s1_pop  <= pop_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[w_idx] <= req.key_code;
    end
    if (accept) begin
      mem_q <= key_store[r_idx];
    end
  end

  assign res_valid = s1_valid;

  always_comb begin
    res_data = s1_data;
    if (s1_pop) begin
      res_data.read_data = mem_q;
    end
  end

  `KDR_ASSERT_NOW(occ_bound_a, clk, rst, 1'b1, occ <= FULL_OCC)
  `KDR_ASSERT_NOW(hold_bound_a, clk, rst, 1'b1, hold_count <= kdr_pkg::REPEAT_COUNT)
  `KDR_ASSERT_NEXT(cmd_keeps_count_a, clk, rst, accept && req.func, $stable(hold_count))
  `KDR_ASSERT_NEXT(drop_keeps_wptr_a, clk, rst, accept && drop, $stable(w_idx))
  `KDR_ASSERT_NEXT(empty_pop_zero_a, clk, rst, pop_empty, s1_valid && (res_data.read_data == 8'd0))

endmodule

// File: rtl/kdr_skid.sv
// Two-word output buffer that decouples the result stage from the receiver.
// Depends on kdr_pkg and kdr_rsp_if.
module kdr_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kdr_pkg::rsp_t in_data,
  kdr_rsp_if.source     rsp
);

  logic [1:0]    count;
  kdr_pkg::rsp_t head;
  kdr_pkg::rsp_t tail;
  logic          push;
  logic          pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = (count != 2'd0) && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          head <= in_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head <= in_data;
        end else if (push) begin
          tail <= in_data;
        end
      end
      2'd2: begin
        // advance the held word into the head
        if (pop) begin
          head <= tail;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid      = (count != 2'd0);
  assign rsp.read_data  = head.read_data;
  assign rsp.read_valid = head.read_valid;
  assign rsp.click      = head.click;
  assign rsp.alarm      = head.alarm;
  assign rsp.led_bits   = head.led_bits;

endmodule
